// File: hdl/tssr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature sensor scratchpad reader package
// Shared types, event and status codes, register indexes and the CRC-8 step.
// ----------------------------------------------------------------------------
package tssr_pkg;

   // Scratchpad frame length in bytes; the last byte carries the CRC.
   localparam int SCRATCHPAD_BYTES = 9;
   localparam int POS_W            = $clog2(SCRATCHPAD_BYTES + 1);

   // Temperature scaling: raw * 5 / 8, truncating toward zero.
   localparam int DECODE_SHIFT = 3;
   localparam int PROD_W       = 19;

   // Reflected CRC-8 polynomial (0x31 reflected).
   localparam logic [7:0] CRC_POLY = 8'h8C;

   // Event codes carried in the action field.
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_BYTE  = 2'd3;

   // Status codes reported with each response.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_BUSY  = 2'd1;
   localparam logic [1:0] STATUS_CRC   = 2'd2;
   localparam logic [1:0] STATUS_RANGE = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_WAIT_TICKS = 2'd0;
   localparam logic [1:0] CSR_MIN_TEMP   = 2'd1;
   localparam logic [1:0] CSR_MAX_TEMP   = 2'd2;
   localparam logic [1:0] CSR_INIT_TEMP  = 2'd3;

   // Configuration reset values.
   localparam logic [15:0]        WAIT_TICKS_RST = 16'd750;
   localparam logic signed [15:0] MIN_TEMP_RST   = -16'sd550;
   localparam logic signed [15:0] MAX_TEMP_RST   = 16'sd1250;
   localparam logic signed [15:0] INIT_TEMP_RST  = 16'sd0;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic signed [15:0] temperature;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        wait_ticks;
      logic signed [15:0] min_temp;
      logic signed [15:0] max_temp;
      logic signed [15:0] init_temp;
   } cfg_type;

   // One byte of the reflected CRC-8, unrolled over its eight bits.
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// File: hdl/tssr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scratchpad reader event core
// Holds the conversion and frame state, applies one accepted request per cycle and
// forms the response that the request causes, if any.
// ----------------------------------------------------------------------------
module tssr_core
   import tssr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    in_fire,
   input  wire req_type in_req,
   output logic         res_valid,
   output rsp_type      res_item
);

   localparam logic [POS_W-1:0] POS_LAST = POS_W'(SCRATCHPAD_BYTES - 1);
   localparam logic [POS_W-1:0] POS_DONE = POS_W'(SCRATCHPAD_BYTES);

   logic                     pend_ff,  pend_in;
   logic [15:0]              elapsed_ff, elapsed_in;
   logic [POS_W-1:0]         pos_ff,   pos_in;
   logic [7:0]               crc_ff,   crc_in;
   logic [15:0]              raw_ff,   raw_in;
   logic signed [15:0]       good_ff,  good_in;
   logic                     seen_ff,  seen_in;

   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] biased;
   logic signed [PROD_W-1:0] scaled;
   logic signed [15:0]       temp_dec;
   logic                     in_range;
   logic [1:0]               status;

   // Decode the raw word: times five by shift and add, then divide by eight
   // with a bias on negative values so the result truncates toward zero.
   always_comb begin
      prod     = {{3{raw_ff[15]}}, raw_ff} + {raw_ff[15], raw_ff, 2'b00};
      biased   = prod + (prod[PROD_W-1] ? PROD_W'(7) : PROD_W'(0));
      scaled   = biased >>> DECODE_SHIFT;
      temp_dec = scaled[15:0];
      in_range = (temp_dec >= cfg.min_temp) && (temp_dec <= cfg.max_temp);
   end

   // Next state and response for the request at the input.
   always_comb begin
      pend_in    = pend_ff;
      elapsed_in = elapsed_ff;
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      raw_in     = raw_ff;
      good_in    = good_ff;
      seen_in    = seen_ff;
      res_valid  = 1'b0;
      status     = STATUS_OK;
      case (in_req.action)
         ACT_START: begin
            pend_in    = 1'b1;
            elapsed_in = '0;
            res_valid  = 1'b1;
         end
         ACT_TICK: begin
            if (elapsed_ff != '1) begin
               elapsed_in = elapsed_ff + 16'd1;
            end
         end
         ACT_READ: begin
            res_valid = 1'b1;
            if (pend_ff && (elapsed_ff < cfg.wait_ticks)) begin
               status = STATUS_BUSY;
            end else begin
               pend_in = 1'b0;
               pos_in  = '0;
               crc_in  = '0;
            end
         end
         ACT_BYTE: begin
            if (pos_ff < POS_DONE) begin
               if (pos_ff == POS_W'(0)) begin
                  raw_in[7:0] = in_req.byte_value;
               end
               if (pos_ff == POS_W'(1)) begin
                  raw_in[15:8] = in_req.byte_value;
               end
               if (pos_ff < POS_LAST) begin
                  crc_in = crc8_step(crc_ff, in_req.byte_value);
                  pos_in = pos_ff + POS_W'(1);
               end else begin
                  // Last byte of the frame: check CRC, then range.
                  pos_in    = POS_DONE;
                  res_valid = 1'b1;
                  if (crc_ff != in_req.byte_value) begin
                     status = STATUS_CRC;
                  end else if (!in_range) begin
                     status = STATUS_RANGE;
                  end else begin
                     good_in = temp_dec;
                     seen_in = 1'b1;
                  end
               end
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      res_item.status      = status;
      res_item.temperature = seen_in ? good_in : cfg.init_temp;
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff    <= 1'b0;
         elapsed_ff <= '0;
         pos_ff     <= '0;
         crc_ff     <= '0;
         raw_ff     <= '0;
         seen_ff    <= 1'b0;
      end else if (in_fire) begin
         pend_ff    <= pend_in;
         elapsed_ff <= elapsed_in;
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         raw_ff     <= raw_in;
         seen_ff    <= seen_in;
      end
   end

   // Last good temperature; only read once the seen flag is set.
   always_ff @(posedge clock) begin
      if (in_fire) begin
         good_ff <= good_in;
      end
   end

endmodule
`default_nettype wire

// File: hdl/tssr_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scratchpad reader response register
// Holds one response until it is taken; frees itself in the cycle it drains.
// ----------------------------------------------------------------------------
module tssr_out_reg
   import tssr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  wire rsp_type load_data,
   output logic         can_load,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // Space is free when empty or when the held response leaves this cycle.
   always_comb begin
      can_load = !valid_ff || rsp_ready;
      valid_in = load || (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
`default_nettype wire

// File: hdl/temp_sensor_scratchpad_reader.sv
// A response is registered and valid in the cycle after the request that causes it.
// Throughput: one request per cycle; ticks and mid-frame bytes give no response.
// Requests stall only while a held response is not taken.
// Reset (synchronous, active high) clears the frame and conversion state,
// empties the response register and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Temperature sensor scratchpad reader
// Conversion timing, scratchpad CRC check and temperature decode.
// ----------------------------------------------------------------------------
module temp_sensor_scratchpad_reader
   import tssr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output rsp_type          rsp_data,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type cfg_ff;
   logic    in_fire;
   logic    res_valid;
   rsp_type res_item;
   logic    can_load;

   // Configuration registers, always writable.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wait_ticks <= WAIT_TICKS_RST;
         cfg_ff.min_temp   <= MIN_TEMP_RST;
         cfg_ff.max_temp   <= MAX_TEMP_RST;
         cfg_ff.init_temp  <= INIT_TEMP_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WAIT_TICKS: cfg_ff.wait_ticks <= csr_data;
            CSR_MIN_TEMP:   cfg_ff.min_temp   <= csr_data;
            CSR_MAX_TEMP:   cfg_ff.max_temp   <= csr_data;
            CSR_INIT_TEMP:  cfg_ff.init_temp  <= csr_data;
            default:        cfg_ff.wait_ticks <= cfg_ff.wait_ticks;
         endcase
      end
   end

   // Request handshake.
   assign req_ready = can_load;
   assign in_fire   = req_valid && req_ready;

   tssr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_fire   (in_fire),
      .in_req    (req_data),
      .res_valid (res_valid),
      .res_item  (res_item)
   );

   tssr_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (in_fire && res_valid),
      .load_data (res_item),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// File: hdl/tssr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Scratchpad reader port checker
// Checks the response behavior seen on the top-level ports.
// ----------------------------------------------------------------------------
module tssr_checker
   import tssr_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire req_type     req_data,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire rsp_type     rsp_data
);

   logic req_fire;
   logic out_free;

   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid || rsp_ready;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // A tick never produces a response.
   a_tick_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.action == ACT_TICK) && out_free |=> !rsp_valid)
      else $error("tick produced a response");

   // A start request is answered at once with status ok.
   a_start_ok: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.action == ACT_START)
      |=> rsp_valid && (rsp_data.status == STATUS_OK))
      else $error("start not answered with ok");

   // A read request is answered at once with ok or busy.
   a_read_status: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.action == ACT_READ)
      |=> rsp_valid && ((rsp_data.status == STATUS_OK) || (rsp_data.status == STATUS_BUSY)))
      else $error("read answered with a frame status");

endmodule

bind temp_sensor_scratchpad_reader tssr_checker u_tssr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
